/* hw/rtl/mig_pkg.sv */
`timescale 1ns / 1ps

package mig_pkg;

	// Operand size in 32-bit words; the datapath width follows from it.
	localparam int OPERAND_WORDS_DEF = 8;

	// Result status codes, carried on the result tuser.
	localparam int STATUS_W = 2;
	localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_BADARG = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_NOGCD  = 2'd2;

	// Operations of the shared wide arithmetic unit.
	localparam int ALU_OP_W = 2;
	localparam logic [ALU_OP_W-1:0] ALU_HALF   = 2'd0; // (p >> 1) + (p odd ? q : 0)
	localparam logic [ALU_OP_W-1:0] ALU_SUBABS = 2'd1; // |p - q|, lt = p < q
	localparam logic [ALU_OP_W-1:0] ALU_SUBMOD = 2'd2; // p - q, plus m when p < q

endpackage

/* hw/rtl/mig_alu.sv */
`timescale 1ns / 1ps

module mig_alu #(
	parameter int DW = 256
) (
	input  logic [mig_pkg::ALU_OP_W-1:0] op,
	input  logic [DW-1:0]                p,
	input  logic [DW-1:0]                q,
	input  logic [DW-1:0]                m,
	output logic [DW-1:0]                res,
	output logic                         lt
);

	always_comb begin
		lt  = (p < q);
		res = '0;
		case (op)
			mig_pkg::ALU_HALF: begin
				res = {1'b0, p[DW-1:1]} + (p[0] ? q : '0);
			end
			mig_pkg::ALU_SUBABS: begin
				res = lt ? (q - p) : (p - q);
			end
			mig_pkg::ALU_SUBMOD: begin
				// When p < q the true difference is negative; adding the
				// modulus brings it back into range, wrapping mod 2^DW.
				res = p - q + (lt ? m : '0);
			end
			default: begin
				res = '0;
			end
		endcase
	end

endmodule

/* hw/rtl/modular_inverse_binary_gcd.sv */
`timescale 1ns / 1ps

// Modular inverse by a constant-time binary extended GCD.
// Input channel (s_*): one transaction carries the value in the low half of
// s_tdata and the odd modulus in the high half. Output channel (m_*): one
// transaction per input, with the inverse on m_tdata and a status on m_tuser
// (0 ok, 1 bad arguments, 2 gcd not one). A zero value gives zero with ok.
// Bad arguments (even modulus, modulus at most one, value not below the
// modulus) and a gcd other than one give a zero inverse.
// The block works on one transaction at a time and s_tready is high only
// while it is idle. A valid transaction runs a fixed 64 * OPERAND_WORDS
// iterations (512 by default), each passing in turn through the single shared
// wide arithmetic unit: halve, compare-and-subtract, modular subtract. An
// argument check and the halving of the modulus come before the loop, and a
// finishing state writes the result to the output register before the block
// returns to idle for the next transaction. Bad arguments skip the loop
// and go from the check straight to the finishing state.
// The result sits in an output register; the block can take the next input
// while it waits, but it holds its own finished result until the receiver
// has emptied that register. Reset clears the sequencer and the output valid.

module modular_inverse_binary_gcd #(
	parameter int OPERAND_WORDS = mig_pkg::OPERAND_WORDS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// s_tdata, from bit 0 up: value (OPERAND_WORDS*32 bits), modulus (same)
	input  logic [OPERAND_WORDS*64-1:0]     s_tdata,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// m_tdata, from bit 0 up: inverse (OPERAND_WORDS*32 bits)
	output logic [OPERAND_WORDS*32-1:0]     m_tdata,
	// m_tuser, from bit 0 up: status (2 bits)
	output logic [mig_pkg::STATUS_W-1:0]    m_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready
);

	localparam int DW         = OPERAND_WORDS * 32;
	localparam int ITERATIONS = OPERAND_WORDS * 64;
	localparam int IT_W       = $clog2(ITERATIONS);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CHK  = 3'd1;
	localparam logic [2:0] S_HALF = 3'd2;
	localparam logic [2:0] S_P0   = 3'd3;
	localparam logic [2:0] S_P1   = 3'd4;
	localparam logic [2:0] S_P2   = 3'd5;
	localparam logic [2:0] S_FIN  = 3'd6;

	logic [2:0]      state_q;
	logic [IT_W-1:0] it_q;

	// Working registers of the extended GCD.
	logic [DW-1:0] x_q, y_q, a_q, b_q, m_q, h_q;
	logic          en_q;       // y was odd in the compare-and-subtract phase
	logic          bad_q;      // argument check failed
	logic          vzero_q;    // value was zero

	logic [DW-1:0]                   inv_q;
	logic [mig_pkg::STATUS_W-1:0]    status_q;
	logic                            mvalid_q;

	// Shared unit operand selection.
	logic [mig_pkg::ALU_OP_W-1:0] alu_op;
	logic [DW-1:0]                alu_p, alu_q, alu_res;
	logic                         alu_lt;

	logic bad_args;
	logic out_free;

	always_comb begin
		alu_op = mig_pkg::ALU_SUBABS;
		alu_p  = y_q;
		alu_q  = x_q;
		case (state_q)
			S_CHK: begin
				alu_op = mig_pkg::ALU_SUBABS;
				alu_p  = y_q;
				alu_q  = x_q;
			end
			S_HALF: begin
				// Modulus is odd here, so this is (modulus >> 1) + 1.
				alu_op = mig_pkg::ALU_HALF;
				alu_p  = m_q;
				alu_q  = DW'(1);
			end
			S_P0: begin
				alu_op = mig_pkg::ALU_HALF;
				alu_p  = b_q;
				alu_q  = h_q;
			end
			S_P1: begin
				alu_op = mig_pkg::ALU_SUBABS;
				alu_p  = y_q;
				alu_q  = x_q;
			end
			S_P2: begin
				alu_op = mig_pkg::ALU_SUBMOD;
				alu_p  = b_q;
				alu_q  = a_q;
			end
			default: begin
				alu_op = mig_pkg::ALU_SUBABS;
				alu_p  = y_q;
				alu_q  = x_q;
			end
		endcase
	end

	mig_alu #(
		.DW(DW)
	) u_alu (
		.op (alu_op),
		.p  (alu_p),
		.q  (alu_q),
		.m  (m_q),
		.res(alu_res),
		.lt (alu_lt)
	);

	// In the check state x holds the modulus and y the value.
	assign bad_args = ~x_q[0] | (x_q == DW'(1)) | ~alu_lt;
	assign out_free = ~mvalid_q | m_tready;
	assign s_tready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			it_q     <= '0;
			mvalid_q <= 1'b0;
		end else begin
			// A finished result refills the output register in the same cycle
			// that the receiver takes the previous one.
			if ((state_q == S_FIN) && out_free) begin
				mvalid_q <= 1'b1;
			end else if (m_tready) begin
				mvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					state_q <= bad_args ? S_FIN : S_HALF;
				end
				S_HALF: begin
					it_q    <= '0;
					state_q <= S_P0;
				end
				S_P0: begin
					state_q <= S_P1;
				end
				S_P1: begin
					state_q <= S_P2;
				end
				S_P2: begin
					if (it_q == IT_W'(ITERATIONS - 1)) begin
						state_q <= S_FIN;
					end else begin
						it_q    <= it_q + IT_W'(1);
						state_q <= S_P0;
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers carry no reset; they are loaded on acceptance or later in the sequence.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					y_q <= s_tdata[DW-1:0];
					x_q <= s_tdata[2*DW-1:DW];
					m_q <= s_tdata[2*DW-1:DW];
					a_q <= '0;
					b_q <= DW'(1);
				end
			end
			S_CHK: begin
				bad_q   <= bad_args;
				vzero_q <= (y_q == '0);
			end
			S_HALF: begin
				h_q <= alu_res;
			end
			S_P0: begin
				// Even y: halve y and halve b modulo the modulus.
				if (!y_q[0]) begin
					y_q <= {1'b0, y_q[DW-1:1]};
					b_q <= alu_res;
				end
			end
			S_P1: begin
				// Odd y: keep y at least x by swapping, then y -= x.
				en_q <= y_q[0];
				if (y_q[0]) begin
					y_q <= alu_res;
					if (alu_lt) begin
						x_q <= y_q;
						a_q <= b_q;
						b_q <= a_q;
					end
				end
			end
			S_P2: begin
				if (en_q) begin
					b_q <= alu_res;
				end
			end
			S_FIN: begin
				if (out_free) begin
					if (bad_q) begin
						inv_q    <= '0;
						status_q <= mig_pkg::STATUS_BADARG;
					end else if (vzero_q) begin
						inv_q    <= '0;
						status_q <= mig_pkg::STATUS_OK;
					end else if (x_q != DW'(1)) begin
						inv_q    <= '0;
						status_q <= mig_pkg::STATUS_NOGCD;
					end else begin
						inv_q    <= a_q;
						status_q <= mig_pkg::STATUS_OK;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tdata  = inv_q;
	assign m_tuser  = status_q;
	assign m_tvalid = mvalid_q;

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

	localparam int WIDE         = mig_pkg::OPERAND_WORDS_DEF * 32;
	localparam int GCD_STEPS    = 64 * mig_pkg::OPERAND_WORDS_DEF;
	localparam int DRAIN_CYCLES = 1700;
	// Slowest run: every transaction through the full loop, plus sender gaps,
	// receiver stalls and the two long hold-offs, then taken about four times.
	localparam int CYCLE_LIMIT  = 8_000_000;
	localparam int HOLD_CYCLES  = 5000;
	localparam int RANDOM_OPS   = 1140;

	typedef logic [WIDE-1:0] wide_t;

	typedef struct {
		wide_t value;
		wide_t modulus;
		bit    drain_first; // wait until every inverse is back before sending
	} operand_pair_t;

	typedef struct {
		wide_t                         inverse;
		logic [mig_pkg::STATUS_W-1:0]  status;
	} inverse_result_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic [2*WIDE-1:0]             s_tdata = '0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [WIDE-1:0]               m_tdata;
	logic [mig_pkg::STATUS_W-1:0]  m_tuser;
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;

	operand_pair_t   pending_ops[$];
	inverse_result_t inverse_q[$];
	int              mismatch_count = 0;
	int              result_count = 0;
	int              cycle_count = 0;

	modular_inverse_binary_gcd u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Constant-time binary extended GCD: a fixed number of steps, each one
	// halving y (and b modulo the modulus) when y is even, then, if y is odd,
	// subtracting the smaller of x and y from the larger with the matching update of b.
	function automatic inverse_result_t compute_inverse(input wide_t value, input wide_t modulus);
		inverse_result_t r;
		wide_t x, y, a, b, half, t;
		logic en, sw, b_odd, borrow;
		int step;
		r.inverse = '0;
		r.status = mig_pkg::STATUS_OK;
		if (!modulus[0] || modulus == wide_t'(1) || value >= modulus) begin
			r.status = mig_pkg::STATUS_BADARG;
			return r;
		end
		x = modulus;
		y = value;
		a = '0;
		b = wide_t'(1);
		half = (modulus >> 1) + wide_t'(1);
		for (step = 0; step < GCD_STEPS; step++) begin
			if (!y[0]) begin
				y = y >> 1;
				b_odd = b[0];
				b = b >> 1;
				if (b_odd)
					b = b + half;
			end
			en = y[0];
			sw = en && (y < x);
			if (sw) begin
				t = x; x = y; y = t;
				t = a; a = b; b = t;
			end
			if (en) begin
				y = y - x;
				borrow = b < a;
				b = b - a;
				if (borrow)
					b = b + modulus;
			end
		end
		if (value == '0)
			r.inverse = '0;
		else if (x != wide_t'(1))
			r.status = mig_pkg::STATUS_NOGCD;
		else
			r.inverse = a;
		return r;
	endfunction

	function automatic wide_t rand_wide();
		wide_t w;
		int k;
		for (k = 0; k < WIDE / 32; k++)
			w[k*32 +: 32] = $urandom;
		return w;
	endfunction

	// Odd modulus above one, often full width, otherwise of a random length.
	function automatic wide_t rand_modulus();
		wide_t m;
		int len;
		if ($urandom_range(0, 49) == 0)
			return '1;
		len = ($urandom_range(0, 1) == 0) ? WIDE : $urandom_range(2, WIDE);
		m = rand_wide();
		if (len < WIDE)
			m = m & ((wide_t'(1) << len) - wide_t'(1));
		m[0] = 1'b1;
		m[len-1] = 1'b1;
		return m;
	endfunction

	task automatic push_op(input wide_t value, input wide_t modulus, input bit drain_first);
		operand_pair_t op;
		op.value = value;
		op.modulus = modulus;
		op.drain_first = drain_first;
		pending_ops.push_back(op);
	endtask

	task automatic report_mismatch(input string field, input logic [63:0] got,
			input logic [63:0] want);
		mismatch_count++;
		$display("ERROR result %0d %s: got %h expected %h", result_count, field, got, want);
	endtask

	// Sender: bursts of transactions separated by random gaps. A transaction
	// that is offered stays offered until the block takes it.
	int burst_left;
	int gap_left;
	always @(posedge clk or negedge arst_n) begin
		operand_pair_t op;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (s_tvalid && s_tready)
				inverse_q.push_back(compute_inverse(s_tdata[WIDE-1:0], s_tdata[2*WIDE-1:WIDE]));
			if (!(s_tvalid && !s_tready)) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (pending_ops.size() != 0 && pending_ops[0].drain_first &&
						inverse_q.size() != 0) begin
					s_tvalid <= 1'b0;
				end else if (pending_ops.size() != 0) begin
					op = pending_ops.pop_front();
					s_tdata <= {op.modulus, op.value};
					s_tvalid <= 1'b1;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 12);
						gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 25);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: ready follows a rotating random pattern, sometimes all ones.
	// Twice it holds off for several full loop times so that the block's
	// output register fills and its input stalls.
	int results_taken;
	int hold_left;
	int pattern_left;
	logic [31:0] stall_pattern;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			results_taken = 0;
			hold_left = 0;
			pattern_left = 0;
			stall_pattern = '1;
		end else begin
			if (m_tvalid && m_tready) begin
				results_taken++;
				if (results_taken == 5 || results_taken == 520)
					hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				if (pattern_left == 0) begin
					stall_pattern = ($urandom_range(0, 2) == 0) ? '1 : $urandom;
					pattern_left = 32;
				end
				m_tready <= stall_pattern[0];
				stall_pattern = {stall_pattern[0], stall_pattern[31:1]};
				pattern_left--;
			end
		end
	end

	// Monitor: each result transaction is checked against the oldest inverse.
	always @(posedge clk) begin
		inverse_result_t want;
		int w;
		if (arst_n && m_tvalid && m_tready) begin
			if (inverse_q.size() == 0) begin
				report_mismatch("with nothing pending", m_tdata[63:0], '0);
			end else begin
				want = inverse_q.pop_front();
				for (w = 0; w < WIDE / 64; w++)
					if (m_tdata[w*64 +: 64] !== want.inverse[w*64 +: 64])
						report_mismatch($sformatf("inverse_w%0d", w),
							m_tdata[w*64 +: 64], want.inverse[w*64 +: 64]);
				if (m_tuser !== want.status)
					report_mismatch("status", 64'(m_tuser), 64'(want.status));
			end
			result_count++;
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("modular_inverse_binary_gcd verification failed");
		$finish;
	end

	initial begin
		wide_t top_bit, v, m;
		int i, sel, d;
		top_bit = wide_t'(1) << (WIDE - 1);

		// Directed: bad arguments of every kind, zero value, the largest
		// modulus, a gcd other than one, and small and edge operands.
		push_op(wide_t'(5), wide_t'(8), 1'b0);
		push_op('0, '0, 1'b0);
		push_op('0, wide_t'(1), 1'b0);
		push_op(wide_t'(7), wide_t'(7), 1'b0);
		push_op('1, wide_t'(13), 1'b0);
		push_op('0, wide_t'(13), 1'b0);
		push_op(wide_t'(1), wide_t'(13), 1'b0);
		push_op(wide_t'(12), wide_t'(13), 1'b0);
		push_op(wide_t'(2), wide_t'(3), 1'b0);
		push_op(wide_t'(6), wide_t'(9), 1'b0);
		push_op(wide_t'(2), '1, 1'b0);
		push_op('1 - wide_t'(1), '1, 1'b0);
		push_op('1, '1, 1'b0);
		push_op('1 >> 1, '1, 1'b0);
		push_op(wide_t'(3), '1, 1'b0);
		push_op('0, '1, 1'b0);
		push_op(top_bit, top_bit | wide_t'(1), 1'b0);
		push_op({(WIDE/4){4'h5}}, {(WIDE/4){4'hA}} | wide_t'(1), 1'b0);
		push_op(wide_t'(3), '1 - wide_t'(1), 1'b0);
		push_op('0, wide_t'(3), 1'b1);
		push_op(wide_t'(1), wide_t'(3), 1'b0);

		// Random: mostly well-formed pairs, some sharing a small factor, and
		// some raw noise that is mostly rejected as bad arguments.
		for (i = 0; i < RANDOM_OPS; i++) begin
			sel = $urandom_range(0, 99);
			if (sel < 12) begin
				v = rand_wide();
				m = rand_wide();
				if ($urandom_range(0, 1) == 0)
					m[0] = 1'b1;
			end else if (sel < 27) begin
				d = 2 * $urandom_range(1, 60) + 1;
				m = ((rand_modulus() >> 8) | wide_t'(1)) * wide_t'(d);
				v = (wide_t'(d) * (rand_wide() >> 8)) % m;
			end else begin
				m = rand_modulus();
				v = rand_wide();
				if ($urandom_range(0, 2) == 0)
					v = v >> $urandom_range(0, WIDE - 1);
				v = v % m;
			end
			push_op(v, m, i == 0 || i == RANDOM_OPS / 2);
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_ops.size() != 0 || s_tvalid)
			@(posedge clk);
		while (inverse_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (inverse_q.size() != 0)
			report_mismatch("never arrived", 64'(inverse_q.size()), '0);

		if (mismatch_count == 0)
			$display("modular_inverse_binary_gcd verification clean");
		else
			$display("modular_inverse_binary_gcd verification failed");
		$finish;
	end

endmodule
